// ----- hdl/cfa_pkg.sv -----
`timescale 1ns / 1ps

package cfa_pkg;

  localparam int unsigned FRACTION_BITS = 13;
  localparam int unsigned QW    = 16;
  localparam int unsigned DEN_W = 32;
  localparam int unsigned MAG_W = 32;
  localparam int unsigned REM_W = MAG_W + FRACTION_BITS;
  localparam int unsigned D_W   = DEN_W + QW - 1;
  localparam int unsigned CMP_W = DEN_W + QW;

  typedef enum logic [1:0] {
    MODE_ADD = 2'd0,
    MODE_SUB = 2'd1,
    MODE_MUL = 2'd2,
    MODE_DIV = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e              mode;
    logic signed [15:0] a_real;
    logic signed [15:0] a_imag;
    logic signed [15:0] b_real;
    logic signed [15:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [15:0] result_real;
    logic signed [15:0] result_imag;
    logic               divide_by_zero;
    logic               saturated;
  } out_t;

  typedef struct packed {
    logic               is_div;
    logic               dz;
    logic               neg_r;
    logic               neg_i;
    logic               sat_r;
    logic               sat_i;
    logic signed [15:0] simple_r;
    logic signed [15:0] simple_i;
  } ctl_t;

  typedef struct packed {
    ctl_t             ctl;
    logic [D_W-1:0]   d;
    logic [REM_W-1:0] rem_r;
    logic [REM_W-1:0] rem_i;
    logic [QW-1:0]    q_r;
    logic [QW-1:0]    q_i;
  } div_t;

endpackage

// ----- hdl/cfa_front.sv -----
`timescale 1ns / 1ps

module cfa_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cfa_pkg::in_t  data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cfa_pkg::div_t data_o
);

  // stage a: products and add/sub
  logic va_q, vb_q, vc_q;
  logic rdy_a, rdy_b, rdy_c;
  cfa_pkg::mode_e     mode_q;
  logic signed [31:0] p0_q, p1_q, p2_q, p3_q, pbr_q, pbi_q;
  logic signed [15:0] sa_r_q, sa_i_q;

  // stage b: sums
  logic               b_div_q;
  logic signed [15:0] sb_r_q, sb_i_q;
  logic signed [32:0] num_r_q, num_i_q;
  logic [cfa_pkg::DEN_W-1:0] den_q;

  cfa_pkg::div_t c_q;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;
  assign valid_o = vc_q;
  assign data_o  = c_q;

  logic signed [15:0] sa_r_d, sa_i_d;
  always_comb begin
    if (data_i.mode == cfa_pkg::MODE_SUB) begin
      sa_r_d = data_i.a_real - data_i.b_real;
      sa_i_d = data_i.a_imag - data_i.b_imag;
    end else begin
      sa_r_d = data_i.a_real + data_i.b_real;
      sa_i_d = data_i.a_imag + data_i.b_imag;
    end
  end

  logic signed [32:0] mr_d, mi_d;
  logic signed [32:0] mr_sh, mi_sh;
  logic signed [15:0] sb_r_d, sb_i_d;
  always_comb begin
    mr_d  = {p0_q[31], p0_q} - {p1_q[31], p1_q};
    mi_d  = {p2_q[31], p2_q} + {p3_q[31], p3_q};
    mr_sh = mr_d >>> cfa_pkg::FRACTION_BITS;
    mi_sh = mi_d >>> cfa_pkg::FRACTION_BITS;
    if (mode_q == cfa_pkg::MODE_MUL) begin
      sb_r_d = mr_sh[15:0];
      sb_i_d = mi_sh[15:0];
    end else begin
      sb_r_d = sa_r_q;
      sb_i_d = sa_i_q;
    end
  end

  logic                      neg_r, neg_i;
  logic [cfa_pkg::MAG_W-1:0] mag_r, mag_i;
  logic [cfa_pkg::REM_W-1:0] dvd_r, dvd_i;
  logic [cfa_pkg::CMP_W-1:0] lim_pos, lim_neg, lim_r, lim_i;
  logic [32:0]               neg_num_r, neg_num_i;
  cfa_pkg::div_t             c_d;
  always_comb begin
    neg_r     = num_r_q[32];
    neg_i     = num_i_q[32];
    neg_num_r = 33'(-num_r_q);
    neg_num_i = 33'(-num_i_q);
    mag_r     = neg_r ? neg_num_r[31:0] : num_r_q[31:0];
    mag_i     = neg_i ? neg_num_i[31:0] : num_i_q[31:0];
    dvd_r     = cfa_pkg::REM_W'(mag_r) << cfa_pkg::FRACTION_BITS;
    dvd_i     = cfa_pkg::REM_W'(mag_i) << cfa_pkg::FRACTION_BITS;
    lim_pos   = cfa_pkg::CMP_W'(den_q) << (cfa_pkg::QW - 1);
    lim_neg   = lim_pos + cfa_pkg::CMP_W'(den_q);
    lim_r     = neg_r ? lim_neg : lim_pos;
    lim_i     = neg_i ? lim_neg : lim_pos;
    c_d.ctl.is_div   = b_div_q;
    c_d.ctl.dz       = (den_q == '0);
    c_d.ctl.neg_r    = neg_r;
    c_d.ctl.neg_i    = neg_i;
    c_d.ctl.sat_r    = cfa_pkg::CMP_W'(dvd_r) >= lim_r;
    c_d.ctl.sat_i    = cfa_pkg::CMP_W'(dvd_i) >= lim_i;
    c_d.ctl.simple_r = sb_r_q;
    c_d.ctl.simple_i = sb_i_q;
    c_d.d            = cfa_pkg::D_W'(den_q) << (cfa_pkg::QW - 1);
    c_d.rem_r        = dvd_r;
    c_d.rem_i        = dvd_i;
    c_d.q_r          = '0;
    c_d.q_i          = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) va_q <= valid_i;
      if (rdy_b) vb_q <= va_q;
      if (rdy_c) vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_a) begin
      mode_q <= data_i.mode;
      p0_q   <= data_i.a_real * data_i.b_real;
      p1_q   <= data_i.a_imag * data_i.b_imag;
      p2_q   <= data_i.a_real * data_i.b_imag;
      p3_q   <= data_i.a_imag * data_i.b_real;
      pbr_q  <= data_i.b_real * data_i.b_real;
      pbi_q  <= data_i.b_imag * data_i.b_imag;
      sa_r_q <= sa_r_d;
      sa_i_q <= sa_i_d;
    end
    if (va_q && rdy_b) begin
      b_div_q <= (mode_q == cfa_pkg::MODE_DIV);
      sb_r_q  <= sb_r_d;
      sb_i_q  <= sb_i_d;
      // a * conj(b)
      num_r_q <= {p0_q[31], p0_q} + {p1_q[31], p1_q};
      num_i_q <= {p3_q[31], p3_q} - {p2_q[31], p2_q};
      den_q   <= cfa_pkg::DEN_W'(pbr_q) + cfa_pkg::DEN_W'(pbi_q);
    end
    if (vb_q && rdy_c) c_q <= c_d;
  end

endmodule

// ----- hdl/cfa_div_step.sv -----
`timescale 1ns / 1ps

module cfa_div_step (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  cfa_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output cfa_pkg::div_t data_o
);

  logic          valid_q;
  cfa_pkg::div_t data_q, data_d;
  logic [cfa_pkg::CMP_W-1:0] d_w, rr_w, ri_w, rr_s, ri_s;
  logic ge_r, ge_i;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // one restoring quotient bit for each component against the shared divisor
  always_comb begin
    d_w  = cfa_pkg::CMP_W'(data_i.d);
    rr_w = cfa_pkg::CMP_W'(data_i.rem_r);
    ri_w = cfa_pkg::CMP_W'(data_i.rem_i);
    ge_r = rr_w >= d_w;
    ge_i = ri_w >= d_w;
    rr_s = ge_r ? rr_w - d_w : rr_w;
    ri_s = ge_i ? ri_w - d_w : ri_w;
    data_d       = data_i;
    data_d.d     = data_i.d >> 1;
    data_d.rem_r = rr_s[cfa_pkg::REM_W-1:0];
    data_d.rem_i = ri_s[cfa_pkg::REM_W-1:0];
    data_d.q_r   = {data_i.q_r[cfa_pkg::QW-2:0], ge_r};
    data_d.q_i   = {data_i.q_i[cfa_pkg::QW-2:0], ge_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) data_q <= data_d;
  end

endmodule

// ----- hdl/complex_fixed_point_alu_unit.sv -----
`timescale 1ns / 1ps
// channel   valid           ready           payload
// in        in_valid_i      in_ready_o      in_data_i  (cfa_pkg::in_t)
// out       out_valid_o     out_ready_i     out_data_o (cfa_pkg::out_t)
//
// one transfer per cycle in each direction while the output is not stalled;
// the pipeline has 3 front stages, 16 divider bit stages, 1 output register
// every stage has its own valid bit and advances into a free slot,
// so bubbles fill up while the output stalls and nothing is dropped
// rst_ni clears only the valid bits

module complex_fixed_point_alu_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  cfa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output cfa_pkg::out_t  out_data_o
);

  logic          v   [cfa_pkg::QW+1];
  logic          rdy [cfa_pkg::QW+1];
  cfa_pkg::div_t dat [cfa_pkg::QW+1];

  cfa_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .data_i  (in_data_i),
    .valid_o (v[0]),
    .ready_i (rdy[0]),
    .data_o  (dat[0])
  );

  for (genvar k = 0; k < cfa_pkg::QW; k++) begin : g_step
    cfa_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v[k]),
      .ready_o (rdy[k]),
      .data_i  (dat[k]),
      .valid_o (v[k+1]),
      .ready_i (rdy[k+1]),
      .data_o  (dat[k+1])
    );
  end

  logic          out_valid_q;
  cfa_pkg::out_t out_q, out_d;
  cfa_pkg::ctl_t c;

  assign rdy[cfa_pkg::QW] = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

  always_comb begin
    c     = dat[cfa_pkg::QW].ctl;
    out_d = '0;
    if (!c.is_div) begin
      out_d.result_real = c.simple_r;
      out_d.result_imag = c.simple_i;
    end else if (c.dz) begin
      out_d.divide_by_zero = 1'b1;
    end else begin
      out_d.saturated = c.sat_r || c.sat_i;
      if (c.sat_r) out_d.result_real = c.neg_r ? 16'sh8000 : 16'sh7fff;
      else if (c.neg_r) out_d.result_real = 16'd0 - dat[cfa_pkg::QW].q_r;
      else out_d.result_real = dat[cfa_pkg::QW].q_r;
      if (c.sat_i) out_d.result_imag = c.neg_i ? 16'sh8000 : 16'sh7fff;
      else if (c.neg_i) out_d.result_imag = 16'd0 - dat[cfa_pkg::QW].q_i;
      else out_d.result_imag = dat[cfa_pkg::QW].q_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rdy[cfa_pkg::QW]) begin
      out_valid_q <= v[cfa_pkg::QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v[cfa_pkg::QW] && rdy[cfa_pkg::QW]) out_q <= out_d;
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 20;
  localparam int CYCLE_LIMIT = 200000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  cfa_pkg::in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  cfa_pkg::out_t out_data_o;

  int error_count = 0;
  int cycle_count = 0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  complex_fixed_point_alu_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o)
  );

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  class alu_scoreboard;
    cfa_pkg::out_t pending_q[$];

    // truncated quotient of num * 2^FRACTION_BITS / den, clamped to 16 bits
    function logic signed [15:0] div_clamp(longint num, longint den, ref bit sat);
      longint mag;
      longint q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< cfa_pkg::FRACTION_BITS) / den;
      if (num < 0) begin
        if (q > 32768) begin
          sat = 1'b1;
          return -16'sd32768;
        end
        return 16'(-q);
      end
      if (q > 32767) begin
        sat = 1'b1;
        return 16'sd32767;
      end
      return 16'(q);
    endfunction

    function cfa_pkg::out_t alu_result(cfa_pkg::in_t it);
      cfa_pkg::out_t r;
      longint ar, ai, br, bi, den;
      bit sat;
      r = '0;
      sat = 1'b0;
      ar = it.a_real;
      ai = it.a_imag;
      br = it.b_real;
      bi = it.b_imag;
      case (it.mode)
        cfa_pkg::MODE_ADD: begin
          r.result_real = 16'(ar + br);
          r.result_imag = 16'(ai + bi);
        end
        cfa_pkg::MODE_SUB: begin
          r.result_real = 16'(ar - br);
          r.result_imag = 16'(ai - bi);
        end
        cfa_pkg::MODE_MUL: begin
          r.result_real = 16'((ar * br - ai * bi) >>> cfa_pkg::FRACTION_BITS);
          r.result_imag = 16'((ar * bi + ai * br) >>> cfa_pkg::FRACTION_BITS);
        end
        default: begin
          den = br * br + bi * bi;
          if (den == 0) r.divide_by_zero = 1'b1;
          else begin
            r.result_real = div_clamp(ar * br + ai * bi, den, sat);
            r.result_imag = div_clamp(ai * br - ar * bi, den, sat);
          end
          r.saturated = sat;
        end
      endcase
      return r;
    endfunction

    function void note_input(cfa_pkg::in_t it);
      pending_q.push_back(alu_result(it));
    endfunction

    task check_result(cfa_pkg::out_t got);
      cfa_pkg::out_t want;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
        return;
      end
      want = pending_q.pop_front();
      if (got.result_real !== want.result_real)
        report_mismatch("result_real", got.result_real, want.result_real);
      if (got.result_imag !== want.result_imag)
        report_mismatch("result_imag", got.result_imag, want.result_imag);
      if (got.divide_by_zero !== want.divide_by_zero)
        report_mismatch("divide_by_zero", got.divide_by_zero, want.divide_by_zero);
      if (got.saturated !== want.saturated)
        report_mismatch("saturated", got.saturated, want.saturated);
    endtask
  endclass

  alu_scoreboard results = new();

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 4) - 2);
      3: return 16'($urandom_range(0, 2047)) - 16'sd1024;
      default: return 16'($urandom);
    endcase
  endfunction

  // drives one transfer and waits for acceptance
  task automatic send_item(input cfa_pkg::in_t it);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    results.note_input(it);
  endtask

  task automatic send_random(input int count);
    cfa_pkg::in_t it;
    int burst;
    int n;
    n = 0;
    while (n < count) begin
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        if (n < count) begin
          it.mode = cfa_pkg::mode_e'($urandom_range(0, 3));
          it.a_real = pick_value();
          it.a_imag = pick_value();
          it.b_real = pick_value();
          it.b_imag = pick_value();
          if ($urandom_range(0, 9) == 0) begin
            it.b_real = '0;
            it.b_imag = '0;
          end
          send_item(it);
          n++;
        end
      end
      if ($urandom_range(0, 2) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic send_directed();
    cfa_pkg::in_t it;
    logic signed [15:0] ext [4];
    ext = '{16'sh7fff, 16'sh8000, 16'sd0, -16'sd1};
    foreach (ext[i]) begin
      for (int m = 0; m < 4; m++) begin
        it.mode = cfa_pkg::mode_e'(m);
        it.a_real = ext[i];
        it.a_imag = ext[3 - i];
        it.b_real = ext[(i + 1) % 4];
        it.b_imag = ext[(i + 2) % 4];
        send_item(it);
      end
    end
    // divide by zero, saturating divide, exact unit divide, most-negative multiply, wrapping subtract
    it = '{cfa_pkg::MODE_DIV, 16'sd100, -16'sd5, 16'sd0, 16'sd0};
    send_item(it);
    it = '{cfa_pkg::MODE_DIV, 16'sh7fff, 16'sh8000, 16'sd1, 16'sd0};
    send_item(it);
    it = '{cfa_pkg::MODE_DIV, 16'sh8000, 16'sd0, 16'sd8192, 16'sd0};
    send_item(it);
    it = '{cfa_pkg::MODE_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
    send_item(it);
    it = '{cfa_pkg::MODE_SUB, 16'sh8000, 16'sh7fff, 16'sd1, -16'sd1};
    send_item(it);
    in_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results.pending_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    send_random(150);
    wait_drained();
    // long receiver hold-off while inputs keep coming
    hold_off = 1'b1;
    fork
      send_random(120);
      begin
        repeat (200) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
    send_random(260);
    wait_drained();
    repeat (LATENCY + 5) @(posedge clk_i);
    if (error_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  // receiver stall pattern
  initial begin
    int phase;
    phase = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off) out_ready_i <= 1'b0;
      else if ((phase / 64) % 3 == 0) out_ready_i <= 1'b1;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) results.check_result(out_data_o);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
